// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked on clk with rst_n low disabling the check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/lru_pkg.sv =====
package lru_pkg;

    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 4;
    localparam int CFG_W   = 5;
    localparam int TIME_W  = 32;
    localparam int FAULT_W = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              restart;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0] fault_count;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } sts_t;

endpackage

// ===== rtl/lru_page_replacement_core.sv =====
// a request beat is loaded, then the compare unit scans the active frames up to a hit or the last one,
// then the result is committed and shown once the output register can take the beat
// one request is handled at a time by the single compare unit, which
// steps through the frame memory one frame per cycle; a held result stalls the next
// reset: rst_n asynchronous active low; frames empty, clocks and fault count zero,
// frame count 16; frame memory contents are left as they are

module lru_page_replacement_core #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lru_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  lru_pkg::req_t             in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output lru_pkg::res_t             out_data
);

    lru_pkg::cmd_t cmd;
    lru_pkg::sts_t sts;

    lru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lru_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/lru_dp.sv =====
`include "assert_macros.svh"

module lru_dp #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lru_pkg::CFG_W-1:0]     cfg_wdata,
    input  lru_pkg::req_t                 in_data,
    input  lru_pkg::cmd_t                 cmd,
    output lru_pkg::sts_t                 sts,
    output lru_pkg::res_t                 out_data
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    // frame store, one read port stepping through the frames
    logic [PAGE_BITS-1:0]       page_mem [FRAMES];
    logic [lru_pkg::TIME_W-1:0] time_mem [FRAMES];

    logic [lru_pkg::CFG_W-1:0]   cfg_reg;
    logic [PAGE_BITS-1:0]        page_reg;
    logic [lru_pkg::TIME_W-1:0]  clock_reg;
    logic [CNT_W-1:0]            filled_reg;
    logic [lru_pkg::FAULT_W-1:0] faults_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic [IDX_W-1:0]            cmp_idx_reg;
    logic                        cmp_vld_reg;
    logic [PAGE_BITS-1:0]        page_rd_reg;
    logic [lru_pkg::TIME_W-1:0]  time_rd_reg;
    logic [lru_pkg::TIME_W-1:0]  best_age_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [PAGE_BITS-1:0]        best_page_reg;
    logic                        hit_reg;
    logic [IDX_W-1:0]            hit_idx_reg;
    lru_pkg::res_t               out_data_reg;

    logic [CNT_W-1:0]            act_cnt;
    logic [IDX_W-1:0]            last_idx;
    logic [lru_pkg::TIME_W-1:0]  age;
    logic                        hit_now;
    logic                        better;
    logic                        not_full;
    logic [IDX_W-1:0]            slot;
    logic [IDX_W-1:0]            rd_idx_next;
    logic [lru_pkg::FAULT_W-1:0] faults_next;
    logic [CNT_W-1:0]            filled_next;

    // zero acts as one, anything above the built count as the built count
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            act_cnt = CNT_W'(1);
        end
        else if (32'(cfg_reg) > 32'(FRAMES))
        begin
            act_cnt = CNT_W'(FRAMES);
        end
        else
        begin
            act_cnt = CNT_W'(cfg_reg);
        end
    end

    assign last_idx = IDX_W'(act_cnt - CNT_W'(1));
    assign not_full = filled_reg < act_cnt;
    assign age      = clock_reg - time_rd_reg;
    assign hit_now  = cmp_vld_reg && (CNT_W'(cmp_idx_reg) < filled_reg)
                      && (page_rd_reg == page_reg);
    // ties keep the lower frame
    assign better   = (cmp_idx_reg == '0) || (age > best_age_reg);
    assign sts.scan_done = cmp_vld_reg && (hit_now || cmp_idx_reg == last_idx);

    assign rd_idx_next = (rd_idx_reg == last_idx) ? rd_idx_reg : rd_idx_reg + IDX_W'(1);

    always_comb
    begin
        if (hit_reg)
        begin
            slot = hit_idx_reg;
        end
        else if (not_full)
        begin
            slot = IDX_W'(filled_reg);
        end
        else
        begin
            slot = best_idx_reg;
        end
    end

    always_comb
    begin
        faults_next = faults_reg;
        filled_next = filled_reg;
        if (!hit_reg)
        begin
            if (faults_reg != lru_pkg::FAULT_MAX)
            begin
                faults_next = faults_reg + lru_pkg::FAULT_W'(1);
            end
            if (not_full)
            begin
                filled_next = filled_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= lru_pkg::CFG_RESET;
            clock_reg   <= '0;
            filled_reg  <= '0;
            faults_reg  <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
                if (in_data.restart)
                begin
                    clock_reg  <= lru_pkg::TIME_W'(1);
                    filled_reg <= '0;
                    faults_reg <= '0;
                end
                else
                begin
                    clock_reg <= clock_reg + lru_pkg::TIME_W'(1);
                end
            end
            if (cmd.scan)
            begin
                rd_idx_reg  <= rd_idx_next;
                cmp_vld_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                filled_reg <= filled_next;
                faults_reg <= faults_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= PAGE_BITS'(in_data.page);
        end
        if (cmd.scan)
        begin
            cmp_idx_reg <= rd_idx_reg;
            if (cmp_vld_reg && better)
            begin
                best_age_reg  <= age;
                best_idx_reg  <= cmp_idx_reg;
                best_page_reg <= page_rd_reg;
            end
            if (sts.scan_done)
            begin
                hit_reg     <= hit_now;
                hit_idx_reg <= cmp_idx_reg;
            end
        end
        if (cmd.commit)
        begin
            out_data_reg.hit           <= hit_reg;
            out_data_reg.frame         <= lru_pkg::FRAME_W'(slot);
            out_data_reg.evicted_valid <= !hit_reg && !not_full;
            out_data_reg.evicted_page  <= (!hit_reg && !not_full)
                                          ? lru_pkg::PAGE_W'(best_page_reg) : '0;
            out_data_reg.fault_count   <= faults_next;
        end
    end

    // frame memory
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            page_mem[slot] <= page_reg;
            time_mem[slot] <= clock_reg;
        end
        if (cmd.scan)
        begin
            page_rd_reg <= page_mem[rd_idx_reg];
            time_rd_reg <= time_mem[rd_idx_reg];
        end
    end

    assign out_data = out_data_reg;

    `ASSERT_ALWAYS(a_filled_range, 32'(filled_reg) <= FRAMES)
    `ASSERT_ALWAYS(a_rd_idx_range, 32'(rd_idx_reg) < FRAMES)
    `ASSERT_NEXT(a_faults_monotonic, !cmd.load, faults_reg >= $past(faults_reg))

endmodule

// ===== rtl/lru_ctrl.sv =====
`include "assert_macros.svh"

module lru_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output lru_pkg::cmd_t cmd,
    input  lru_pkg::sts_t sts
);

    lru_pkg::state_t state_reg;
    lru_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lru_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            lru_pkg::ST_IDLE:
            begin
                // a waiting result does not hold off the next request
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lru_pkg::ST_SCAN;
                end
            end
            lru_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = lru_pkg::ST_FINISH;
                end
            end
            lru_pkg::ST_FINISH:
            begin
                // update frames only once the output register can take the beat
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lru_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `ASSERT_IMPLIES(a_commit_slot_free, cmd.commit, !out_valid_reg || out_ready)
    `ASSERT_NEXT(a_commit_shows_beat, cmd.commit, out_valid_reg)
    `ASSERT_IMPLIES(a_ready_only_idle, in_ready, state_reg == lru_pkg::ST_IDLE)

endmodule
